/* rtl/core/plru_pkg.sv */
// Shared types and constants for the pinned LRU table cache directory.
// Holds the request and result structs, status codes and the sequencer program.
// No dependencies.
package plru_pkg;

  // Fixed geometry of the directory
  localparam int SLOTS         = 16;
  localparam int SLOT_BITS     = 4;
  localparam int OCC_BITS      = 5;
  localparam int MODE_BITS     = 4;
  localparam int TEMP_BITS     = 6;
  localparam int PIN_BITS      = 8;
  localparam int CAP_BITS      = 5;
  localparam int STEP_BITS     = 3;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);
  localparam logic [PIN_BITS-1:0] PIN_MAX   = '1;

  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_PIN   = 2'd1,
    REQ_UNPIN = 2'd2,
    REQ_PEEK  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_AVAIL  = 3'd1,
    ST_NOT_RES    = 3'd2,
    ST_UNBALANCED = 3'd3,
    ST_STORE_FULL = 3'd4,
    ST_PIN_SAT    = 3'd5
  } status_t;

  typedef struct packed {
    req_type_t            req_type;
    logic [MODE_BITS-1:0] mode;
    logic [TEMP_BITS-1:0] tbin;
    logic                 table_available;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 evicted;
    logic [MODE_BITS-1:0] evicted_mode;
    logic [TEMP_BITS-1:0] evicted_tbin;
    logic [PIN_BITS-1:0]  pin_count;
  } rsp_t;

  // Sequencer control word: datapath operation, branch condition, branch target
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SCAN,
    OP_DECIDE,
    OP_EVICT,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_START,
    COND_SCAN_MORE,
    COND_NO_EVICT
  } cond_t;

  typedef logic [STEP_BITS-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SCAN   = 3'd1;
  localparam step_t STEP_DECIDE = 3'd2;
  localparam step_t STEP_EVICT  = 3'd3;
  localparam step_t STEP_FINISH = 3'd4;

  // Program ROM: branch to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      STEP_IDLE:   w = '{op: OP_IDLE,   cond: COND_NO_START,  target: STEP_IDLE};
      STEP_SCAN:   w = '{op: OP_SCAN,   cond: COND_SCAN_MORE, target: STEP_SCAN};
      STEP_DECIDE: w = '{op: OP_DECIDE, cond: COND_NO_EVICT,  target: STEP_FINISH};
      STEP_EVICT:  w = '{op: OP_EVICT,  cond: COND_ALWAYS,    target: STEP_SCAN};
      STEP_FINISH: w = '{op: OP_FINISH, cond: COND_ALWAYS,    target: STEP_IDLE};
      default:     w = '{op: OP_IDLE,   cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/pinned_lru_table_cache.sv */
// Pinned LRU table cache directory: top level with microcoded sequencer and datapath.
// Depends on plru_pkg.
//
// Usage:
//   Request channel: present a request on `request` and raise `start`; it is taken
//   at a clock edge where start is high and busy is low. busy stays high until the
//   result has been produced.
//   Result channel: `done` pulses for one cycle with the result on `result`.
//   The receiver cannot stall; the result must be captured in that cycle.
//   Config channel: capacity is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while the block is idle.
//
// Sequence: a request passes through the idle/accept step, a scan of all 16 slots,
// one decide step and the finish step, with done in the following cycle, during which
// the next request can already be accepted. Each eviction adds an evict step, a
// rescan and another decide. The slot scan walks one directory entry per cycle.
// Reset: all slots invalid, use counter zero, capacity 8, sequencer idle.
module pinned_lru_table_cache #(
  parameter int STAMP_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  plru_pkg::req_t                    request,
  output logic                              done,
  output plru_pkg::rsp_t                    result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [plru_pkg::CAP_BITS-1:0]     cfg_data
);
  import plru_pkg::*;

  // Directory storage
  logic [SLOTS-1:0]      slot_valid;
  logic [MODE_BITS-1:0]  slot_mode     [SLOTS];
  logic [TEMP_BITS-1:0]  slot_tbin     [SLOTS];
  logic [STAMP_BITS-1:0] slot_stamp    [SLOTS];
  logic [PIN_BITS-1:0]   slot_pins     [SLOTS];
  logic [STAMP_BITS-1:0] use_counter;
  logic [CAP_BITS-1:0]   capacity;

  // Sequencer
  step_t  step;
  ucode_t uword;
  logic   cond_true;

  // Latched request and scan accumulators
  req_t                  req;
  logic [SLOT_BITS-1:0]  idx;
  logic [OCC_BITS-1:0]   occ;
  logic                  match_found;
  logic [SLOT_BITS-1:0]  match_slot;
  logic [PIN_BITS-1:0]   match_pins;
  logic                  vict_found;
  logic [SLOT_BITS-1:0]  vict_slot;
  logic [STAMP_BITS-1:0] vict_stamp;
  logic [MODE_BITS-1:0]  vict_mode;
  logic [TEMP_BITS-1:0]  vict_temp;
  logic                  free_found;
  logic [SLOT_BITS-1:0]  free_slot;
  logic                  ev_flag;
  logic [MODE_BITS-1:0]  ev_mode;
  logic [TEMP_BITS-1:0]  ev_temp;

  // Per-entry view at the scan pointer
  logic                  e_valid;
  logic                  e_match;
  logic                  e_victim;
  logic [CAP_BITS-1:0]   cap_eff;
  logic                  ins_path;
  logic                  need_evict;
  logic                  accept;
  logic                  clear_scan;

  // Finish-step results
  status_t               fin_status;
  logic [SLOT_BITS-1:0]  fin_slot;
  logic [PIN_BITS-1:0]   fin_pins;
  logic                  fin_write;
  logic                  fin_insert;
  logic [PIN_BITS-1:0]   cur_pins;
  logic [STAMP_BITS-1:0] counter_inc;

  assign uword     = ucode_rom(step);
  assign busy      = (step != STEP_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = (uword.op == OP_IDLE) && start;
  assign clear_scan = accept || (uword.op == OP_EVICT);

  // Entry decode at the scan pointer
  assign e_valid  = slot_valid[idx];
  assign e_match  = e_valid && (slot_mode[idx] == req.mode) &&
                    (slot_tbin[idx] == req.tbin);
  assign e_victim = e_valid && (slot_pins[idx] == '0) &&
                    (!vict_found || (slot_stamp[idx] < vict_stamp));

  // Effective capacity: zero means one, clipped to the slot count
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_BITS'(1);
    end else if (capacity > CAP_BITS'(SLOTS)) begin
      cap_eff = CAP_BITS'(SLOTS);
    end else begin
      cap_eff = capacity;
    end
  end

  assign ins_path   = !match_found && req.table_available &&
                      ((req.req_type == REQ_GET) || (req.req_type == REQ_PIN));
  assign need_evict = ins_path && (occ >= cap_eff) && vict_found;

  // Branch condition
  always_comb begin
    case (uword.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_NO_START:  cond_true = !start;
      COND_SCAN_MORE: cond_true = (idx != SLOT_BITS'(SLOTS - 1));
      COND_NO_EVICT:  cond_true = !need_evict;
      default:        cond_true = 1'b1;
    endcase
  end

  assign counter_inc = use_counter + STAMP_BITS'(1);

  // Outcome of the request, from the final scan
  always_comb begin
    fin_status = ST_OK;
    fin_slot   = '0;
    fin_pins   = '0;
    fin_write  = 1'b0;
    fin_insert = 1'b0;
    cur_pins   = match_pins;
    case (req.req_type)
      REQ_GET, REQ_PIN: begin
        if (match_found) begin
          fin_write = 1'b1;
          fin_slot  = match_slot;
        end else if (!req.table_available) begin
          fin_status = ST_NOT_AVAIL;
        end else if (free_found) begin
          fin_write  = 1'b1;
          fin_insert = 1'b1;
          fin_slot   = free_slot;
          cur_pins   = '0;
        end else begin
          fin_status = ST_STORE_FULL;
        end
        if (fin_write) begin
          fin_pins = cur_pins;
          if (req.req_type == REQ_PIN) begin
            if (cur_pins == PIN_MAX) begin
              fin_status = ST_PIN_SAT;
            end else begin
              fin_pins = cur_pins + PIN_BITS'(1);
            end
          end
        end
      end
      REQ_UNPIN: begin
        if (!match_found) begin
          fin_status = ST_NOT_RES;
        end else begin
          fin_slot = match_slot;
          fin_pins = match_pins;
          if (match_pins == '0) begin
            fin_status = ST_UNBALANCED;
          end else begin
            fin_pins  = match_pins - PIN_BITS'(1);
            fin_write = 1'b1;
          end
        end
      end
      default: begin
        if (!match_found) begin
          fin_status = ST_NOT_RES;
        end else begin
          fin_slot = match_slot;
          fin_pins = match_pins;
        end
      end
    endcase
  end

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_IDLE;
      slot_valid  <= '0;
      use_counter <= '0;
      capacity    <= CAP_RESET;
      done        <= 1'b0;
    end else begin
      step <= cond_true ? uword.target : step + STEP_BITS'(1);
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end

      if (accept) begin
        req     <= request;
        ev_flag <= 1'b0;
        ev_mode <= '0;
        ev_temp <= '0;
      end

      if (clear_scan) begin
        idx         <= '0;
        occ         <= '0;
        match_found <= 1'b0;
        vict_found  <= 1'b0;
        free_found  <= 1'b0;
      end

      case (uword.op)
        OP_SCAN: begin
          idx <= idx + SLOT_BITS'(1);
          if (e_valid) begin
            occ <= occ + OCC_BITS'(1);
          end
          if (e_match && !match_found) begin
            match_found <= 1'b1;
            match_slot  <= idx;
            match_pins  <= slot_pins[idx];
          end
          if (e_victim) begin
            vict_found <= 1'b1;
            vict_slot  <= idx;
            vict_stamp <= slot_stamp[idx];
            vict_mode  <= slot_mode[idx];
            vict_temp  <= slot_tbin[idx];
          end
          if (!e_valid && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= idx;
          end
        end
        OP_EVICT: begin
          slot_valid[vict_slot] <= 1'b0;
          ev_flag <= 1'b1;
          ev_mode <= vict_mode;
          ev_temp <= vict_temp;
        end
        OP_FINISH: begin
          done <= 1'b1;
          result.status       <= fin_status;
          result.hit          <= match_found;
          result.slot         <= fin_slot;
          result.evicted      <= ev_flag;
          result.evicted_mode <= ev_mode;
          result.evicted_tbin <= ev_temp;
          result.pin_count    <= fin_pins;
          if (fin_write) begin
            slot_pins[fin_slot] <= fin_pins;
          end
          // Stamp on every get or pin that lands in a slot
          if (fin_write && (req.req_type != REQ_UNPIN)) begin
            use_counter          <= counter_inc;
            slot_stamp[fin_slot] <= counter_inc;
          end
          if (fin_insert) begin
            slot_valid[fin_slot] <= 1'b1;
            slot_mode[fin_slot]  <= req.mode;
            slot_tbin[fin_slot]  <= req.tbin;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sim/pinned_lru_table_cache_tb.sv */
// Self-checking testbench for the pinned LRU table cache directory.
// Predicts every result from a local copy of the directory and checks each done pulse.
// Depends on plru_pkg and pinned_lru_table_cache.
module pinned_lru_table_cache_tb;
  import plru_pkg::*;

  // One queued operation: a request, or a capacity write between phases
  typedef struct packed {
    logic                is_cfg;
    logic [CAP_BITS-1:0] cap;
    req_t                req;
  } pend_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  req_t                request = '0;
  logic                done;
  rsp_t                result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data = '0;

  pinned_lru_table_cache u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  pend_t pending[$];
  rsp_t  expected_rsps[$];

  // Local copy of the directory
  logic                 dir_valid [SLOTS];
  logic [MODE_BITS-1:0] dir_mode  [SLOTS];
  logic [TEMP_BITS-1:0] dir_temp  [SLOTS];
  logic [31:0]          dir_stamp [SLOTS];
  logic [PIN_BITS-1:0]  dir_pins  [SLOTS];
  logic [31:0]          use_clock;
  logic [CAP_BITS-1:0]  cap_reg;

  // Lookup keys reused by the random part so that hits and evictions happen
  logic [MODE_BITS-1:0] pool_mode [16];
  logic [TEMP_BITS-1:0] pool_temp [16];

  int gap_left = 0;
  int burst_left = 1;
  int n_sent = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_evict = 0;
  int n_full = 0;
  int n_sat = 0;
  int mismatches = 0;

  // Applies one request to the local directory and returns its result
  function automatic rsp_t directory_access(req_t r);
    rsp_t o;
    int   s, v, occ, lim;
    logic settled;
    o = '0;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && dir_valid[i] && dir_mode[i] == r.mode && dir_temp[i] == r.tbin)
        s = i;
    o.hit = (s >= 0);
    case (r.req_type)
      REQ_GET, REQ_PIN: begin
        if (s < 0) begin
          if (!r.table_available) begin
            o.status = ST_NOT_AVAIL;
          end else begin
            lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : int'(cap_reg));
            // evict oldest unpinned while at or above capacity
            settled = 1'b0;
            while (!settled) begin
              occ = 0;
              v = -1;
              for (int i = 0; i < SLOTS; i++) begin
                if (dir_valid[i]) occ++;
                if (dir_valid[i] && dir_pins[i] == 0 && (v < 0 || dir_stamp[i] < dir_stamp[v]))
                  v = i;
              end
              if (occ < lim || v < 0) begin
                settled = 1'b1;
              end else begin
                dir_valid[v] = 1'b0;
                o.evicted = 1'b1;
                o.evicted_mode = dir_mode[v];
                o.evicted_tbin = dir_temp[v];
              end
            end
            for (int i = 0; i < SLOTS; i++)
              if (s < 0 && !dir_valid[i]) s = i;
            if (s < 0) begin
              o.status = ST_STORE_FULL;
            end else begin
              dir_valid[s] = 1'b1;
              dir_mode[s] = r.mode;
              dir_temp[s] = r.tbin;
              dir_pins[s] = '0;
            end
          end
        end
        if (s >= 0) begin
          use_clock = use_clock + 1;
          dir_stamp[s] = use_clock;
          if (r.req_type == REQ_PIN) begin
            if (dir_pins[s] == PIN_MAX) o.status = ST_PIN_SAT;
            else dir_pins[s] = dir_pins[s] + 1'b1;
          end
          o.slot = SLOT_BITS'(s);
          o.pin_count = dir_pins[s];
        end
      end
      REQ_UNPIN: begin
        if (s < 0) begin
          o.status = ST_NOT_RES;
        end else begin
          if (dir_pins[s] == 0) o.status = ST_UNBALANCED;
          else dir_pins[s] = dir_pins[s] - 1'b1;
          o.slot = SLOT_BITS'(s);
          o.pin_count = dir_pins[s];
        end
      end
      default: begin
        if (s < 0) begin
          o.status = ST_NOT_RES;
        end else begin
          o.slot = SLOT_BITS'(s);
          o.pin_count = dir_pins[s];
        end
      end
    endcase
    return o;
  endfunction

  task automatic push_req(req_type_t t, logic [MODE_BITS-1:0] m,
                          logic [TEMP_BITS-1:0] tb, logic avail);
    pend_t p;
    p = '0;
    p.req.req_type = t;
    p.req.mode = m;
    p.req.tbin = tb;
    p.req.table_available = avail;
    pending.insert(pending.size(), p);
  endtask

  task automatic push_cap(logic [CAP_BITS-1:0] value);
    pend_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.cap = value;
    pending.insert(pending.size(), p);
  endtask

  // Random traffic over the key pool; with_fill pins each of the sixteen pool keys once
  task automatic random_phase(int picks, bit with_fill);
    int        k, kind, fill_at;
    req_type_t t;
    fill_at = with_fill ? $urandom_range(0, picks - 1) : -1;
    for (int n = 0; n < picks; n++) begin
      k = $urandom_range(0, 15);
      kind = $urandom_range(0, 9);
      if (n == fill_at) begin
        for (int i = 0; i < 16; i++) push_req(REQ_PIN, pool_mode[i], pool_temp[i], 1'b1);
        push_req(REQ_GET, pool_mode[0], pool_temp[0] ^ 6'd1, 1'b1);
        for (int i = 0; i < 16; i++) push_req(REQ_UNPIN, pool_mode[i], pool_temp[i], 1'b1);
      end else if (kind <= 5) begin
        t = req_type_t'($urandom_range(0, 3));
        push_req(t, pool_mode[k], pool_temp[k], $urandom_range(0, 7) != 0);
      end else if (kind <= 7) begin
        // pinned use of one key, balanced
        push_req(REQ_PIN, pool_mode[k], pool_temp[k], 1'b1);
        push_req(REQ_GET, pool_mode[k], pool_temp[k], 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) push_req(REQ_PEEK, pool_mode[k], pool_temp[k], 1'b0);
        push_req(REQ_UNPIN, pool_mode[k], pool_temp[k], 1'b1);
      end else begin
        t = req_type_t'($urandom_range(0, 3));
        push_req(t, MODE_BITS'($urandom), TEMP_BITS'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Driver: presents queued requests in bursts, capacity writes only when idle
  always @(posedge clk) begin : drive
    pend_t head;
    logic  go, cfg_go;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      request <= '0;
      cfg_data <= '0;
      for (int i = 0; i < SLOTS; i++) dir_valid[i] = 1'b0;
      use_clock = '0;
      cap_reg = CAP_RESET;
    end else begin
      if (start && !busy) begin
        expected_rsps.insert(expected_rsps.size(), directory_access(request));
        void'(pending.pop_front());
        n_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        void'(pending.pop_front());
        n_cfg++;
      end
      go = 1'b0;
      cfg_go = 1'b0;
      if (start && busy) begin
        go = 1'b1;
      end else if (cfg_valid && !cfg_ready) begin
        cfg_go = 1'b1;
      end else if (pending.size() != 0) begin
        head = pending[0];
        if (head.is_cfg) begin
          // wait until the last outstanding result is on its way out
          if (!start && !busy && !cfg_valid &&
              (expected_rsps.size() == 0 || (expected_rsps.size() == 1 && done))) begin
            cfg_go = 1'b1;
            cfg_data <= head.cap;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          go = 1'b1;
          request <= head.req;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
          end
        end
      end
      start <= go;
      cfg_valid <= cfg_go;
    end
  end

  // Monitor: every done pulse is matched against the oldest prediction
  always @(posedge clk) begin : check
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d slot=%0d pins=%0d",
                   result.status, result.slot, result.pin_count);
      end else begin
        want = expected_rsps.pop_front();
        n_checked++;
        if (want.evicted) n_evict++;
        if (want.status == ST_STORE_FULL) n_full++;
        if (want.status == ST_PIN_SAT) n_sat++;
        if (result.status !== want.status || result.hit !== want.hit ||
            result.slot !== want.slot || result.evicted !== want.evicted ||
            result.evicted_mode !== want.evicted_mode ||
            result.evicted_tbin !== want.evicted_tbin ||
            result.pin_count !== want.pin_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch on result %0d: expected st=%0d hit=%0b slot=%0d ev=%0b ",
                      "ev_key=%0d/%0d pins=%0d, got st=%0d hit=%0b slot=%0d ev=%0b ",
                      "ev_key=%0d/%0d pins=%0d"}, n_checked,
                     want.status, want.hit, want.slot, want.evicted, want.evicted_mode,
                     want.evicted_tbin, want.pin_count,
                     result.status, result.hit, result.slot, result.evicted,
                     result.evicted_mode, result.evicted_tbin, result.pin_count);
        end
      end
    end
  end

  // Stimulus: directed checks, random phases over several capacities, pin saturation
  initial begin
    for (int i = 0; i < 16; i++) begin
      pool_mode[i] = MODE_BITS'(i);
      pool_temp[i] = TEMP_BITS'($urandom);
    end
    pool_temp[0] = '0;
    pool_temp[15] = '1;

    // absent keys, table miss, insert, hit, unbalanced unpin, pin/unpin
    push_req(REQ_PEEK,  4'h0, 6'h00, 1'b0);
    push_req(REQ_UNPIN, 4'hF, 6'h3F, 1'b1);
    push_req(REQ_GET,   4'h0, 6'h00, 1'b0);
    push_req(REQ_PIN,   4'h0, 6'h00, 1'b0);
    push_req(REQ_GET,   4'h0, 6'h00, 1'b1);
    push_req(REQ_GET,   4'hF, 6'h3F, 1'b1);
    push_req(REQ_GET,   4'h0, 6'h00, 1'b0);
    push_req(REQ_UNPIN, 4'h0, 6'h00, 1'b1);
    push_req(REQ_PIN,   4'hF, 6'h3F, 1'b0);
    push_req(REQ_PEEK,  4'hF, 6'h3F, 1'b0);
    push_req(REQ_UNPIN, 4'hF, 6'h3F, 1'b0);
    push_req(REQ_PIN,   4'h5, 6'h2A, 1'b1);
    push_req(REQ_PEEK,  4'h0, 6'h00, 1'b1);
    // capacity zero behaves as one: multi-eviction that skips the pinned key
    push_cap(5'd0);
    push_req(REQ_GET,   4'hA, 6'h15, 1'b1);
    push_req(REQ_GET,   4'h3, 6'h03, 1'b1);
    // capacity above the slot count
    push_cap(5'd31);
    push_req(REQ_UNPIN, 4'h5, 6'h2A, 1'b0);
    push_req(REQ_PEEK,  4'h5, 6'h2A, 1'b0);

    random_phase(16, 1'b1);
    push_cap(5'd16);
    random_phase(16, 1'b1);
    push_cap(5'd1);
    random_phase(16, 1'b0);
    push_cap(5'd3);
    random_phase(16, 1'b0);
    push_cap(5'd12);
    random_phase(16, 1'b0);
    push_cap(5'd2);
    random_phase(16, 1'b0);

    // drive one key's pin count into saturation and back
    push_cap(5'd4);
    for (int i = 0; i < 256; i++) push_req(REQ_PIN, 4'h6, 6'h11, 1'b1);
    push_req(REQ_PEEK,  4'h6, 6'h11, 1'b0);
    push_req(REQ_UNPIN, 4'h6, 6'h11, 1'b0);
    push_req(REQ_PIN,   4'h6, 6'h11, 1'b0);
    push_req(REQ_PIN,   4'h6, 6'h11, 1'b0);
    push_req(REQ_GET,   4'h6, 6'h11, 1'b0);
    random_phase(8, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || expected_rsps.size() != 0 || start) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d results of %0d requests across %0d capacity writes;",
             n_checked, n_sent, n_cfg);
    $display("  %0d with evictions, %0d store full, %0d pin saturated, %0d mismatches.",
             n_evict, n_full, n_sat, mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
